FILE: rtl/core/bou_pkg.sv
package bou_pkg;

	localparam logic [63:0] NO_FILE_A = 64'hfefe_fefe_fefe_fefe;
	localparam logic [63:0] NO_FILE_H = 64'h7f7f_7f7f_7f7f_7f7f;
	localparam logic [63:0] ALL_SQUARES = 64'hffff_ffff_ffff_ffff;
	localparam logic [63:0] DIAG_K1 = 64'h0f0f_0f0f_0000_0000;
	localparam logic [63:0] DIAG_K2 = 64'h3333_0000_3333_0000;
	localparam logic [63:0] DIAG_K4 = 64'h5500_5500_5500_5500;

	localparam int KIND_W = 5;
	localparam int BOARD_W = 64;
	localparam int COUNT_W = 7;
	localparam int SHAMT_W = 7;

	typedef enum logic [1:0] {
		GRP_SHIFT = 2'd0,
		GRP_FILL = 2'd1,
		GRP_ATTACK = 2'd2,
		GRP_MISC = 2'd3
	} grp_t;

	typedef enum logic [2:0] {
		DIR_N = 3'd0,
		DIR_S = 3'd1,
		DIR_E = 3'd2,
		DIR_W = 3'd3,
		DIR_NE = 3'd4,
		DIR_NW = 3'd5,
		DIR_SE = 3'd6,
		DIR_SW = 3'd7
	} dir_t;

	typedef enum logic [2:0] {
		OP_SCAN = 3'd0,
		OP_POPCNT = 3'd1,
		OP_LZC = 3'd2,
		OP_VFLIP = 3'd3,
		OP_DFLIP = 3'd4,
		OP_ROTCW = 3'd5,
		OP_ROTCCW = 3'd6,
		OP_GENSHIFT = 3'd7
	} op_t;

	// move by (direction step << k) squares, no masking
	function automatic logic [63:0] dir_move(logic [63:0] x, dir_t d, logic [1:0] k);
		logic [5:0] step_len;
		logic left;
		unique case (d)
			DIR_N: begin step_len = 6'd8; left = 1'b1; end
			DIR_S: begin step_len = 6'd8; left = 1'b0; end
			DIR_E: begin step_len = 6'd1; left = 1'b1; end
			DIR_W: begin step_len = 6'd1; left = 1'b0; end
			DIR_NE: begin step_len = 6'd9; left = 1'b1; end
			DIR_NW: begin step_len = 6'd7; left = 1'b1; end
			DIR_SE: begin step_len = 6'd7; left = 1'b0; end
			DIR_SW: begin step_len = 6'd9; left = 1'b0; end
			default: begin step_len = 6'd0; left = 1'b0; end
		endcase
		step_len = step_len << k;
		return left ? (x << step_len) : (x >> step_len);
	endfunction

	function automatic logic [63:0] src_mask(dir_t d);
		unique case (d)
			DIR_N, DIR_S: return ALL_SQUARES;
			DIR_E, DIR_NE, DIR_SE: return NO_FILE_H;
			default: return NO_FILE_A;
		endcase
	endfunction

	function automatic logic [63:0] empty_mask(dir_t d);
		unique case (d)
			DIR_N, DIR_S: return ALL_SQUARES;
			DIR_E, DIR_NE, DIR_SE: return NO_FILE_A;
			default: return NO_FILE_H;
		endcase
	endfunction

	function automatic logic [63:0] step_one(logic [63:0] x, dir_t d);
		return dir_move(x & src_mask(d), d, 2'd0);
	endfunction

	function automatic logic [63:0] flip_vert(logic [63:0] x);
		logic [63:0] r;
		for (int i = 0; i < 8; i++) begin
			r[8*(7-i) +: 8] = x[8*i +: 8];
		end
		return r;
	endfunction

	function automatic logic [63:0] flip_diag(logic [63:0] x);
		logic [63:0] t;
		logic [63:0] y;
		y = x;
		t = DIAG_K1 & (y ^ (y << 28));
		y = y ^ t ^ (t >> 28);
		t = DIAG_K2 & (y ^ (y << 14));
		y = y ^ t ^ (t >> 14);
		t = DIAG_K4 & (y ^ (y << 7));
		y = y ^ t ^ (t >> 7);
		return y;
	endfunction

	// two's complement amount: positive left, negative right, -64 clears
	function automatic logic [63:0] signed_shift(logic [63:0] x, logic [6:0] amt);
		logic [6:0] mag;
		mag = 7'd0 - amt;
		if (!amt[6]) begin
			return x << amt[5:0];
		end
		if (mag[6]) begin
			return '0;
		end
		return x >> mag[5:0];
	endfunction

endpackage

FILE: rtl/core/bitboard_operation_unit.sv
// Bitboard operation unit: one 64-bit chess bitboard operation per request.
// Request channel (req_valid/req_ready): kind, board, empty_squares, shift_amount.
//   kind 0-7 one-step shifts N,S,E,W,NE,NW,SE,SW; 8-15 occluded fills; 16-23 sliding
//   attacks; 24 bit scan forward, 25 popcount, 26 leading zeros, 27 vertical flip,
//   28 a1-h8 flip, 29 rotate cw, 30 rotate ccw, 31 signed generalised shift.
// Response channel (rsp_valid/rsp_ready): result_board, result_count, zero_input.
// Throughput: one request per cycle while rsp_ready is high. Three register stages,
//   one Kogge-Stone fill step in each, lie between request and response; counts
//   are byte-wise in stage 1 and combined in stage 2.
// Stall: when rsp_ready is low the response holds and each stage keeps its
//   request; the pipeline compacts into empty stages, so up to three requests
//   are taken while the receiver stalls before req_ready drops.
// Reset: arst_n clears all valid bits; req_ready is high straight after reset.
module bitboard_operation_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  logic [bou_pkg::KIND_W-1:0]         kind,
	input  logic [bou_pkg::BOARD_W-1:0]        board,
	input  logic [bou_pkg::BOARD_W-1:0]        empty_squares,
	input  logic signed [bou_pkg::SHAMT_W-1:0] shift_amount,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output logic [bou_pkg::BOARD_W-1:0]        result_board,
	output logic [bou_pkg::COUNT_W-1:0]        result_count,
	output logic                               zero_input
);

	logic vld_s1, vld_s2, vld_s3;
	logic adv_s1, adv_s2, adv_s3;

	logic [bou_pkg::KIND_W-1:0] kind_s1, kind_s2;
	logic [63:0] data_s1, empty_s1;
	logic [63:0] data_s2, empty_s2;
	logic [3:0] bytecnt_s1 [8];
	logic [bou_pkg::COUNT_W-1:0] cnt_s2;
	logic zero_s2;

	logic [63:0] rb_s3;
	logic [bou_pkg::COUNT_W-1:0] cnt_s3;
	logic zero_s3;

	assign adv_s3 = !vld_s3 || rsp_ready;
	assign adv_s2 = !vld_s2 || adv_s3;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign req_ready = adv_s1;

	// stage 1: first fill step, one-step shifts, flips, rotations, generalised shift, byte counts
	bou_pkg::grp_t grp_in;
	bou_pkg::dir_t dir_in;
	bou_pkg::op_t op_in;
	logic [63:0] e0, fill1, efill1, misc_in, data_d1;
	logic [3:0] bytecnt_d1 [8];

	always_comb begin
		grp_in = bou_pkg::grp_t'(kind[4:3]);
		dir_in = bou_pkg::dir_t'(kind[2:0]);
		op_in = bou_pkg::op_t'(kind[2:0]);
		e0 = empty_squares & bou_pkg::empty_mask(dir_in);
		fill1 = board | (e0 & bou_pkg::dir_move(board, dir_in, 2'd0));
		efill1 = e0 & bou_pkg::dir_move(e0, dir_in, 2'd0);
		unique case (op_in)
			bou_pkg::OP_VFLIP: misc_in = bou_pkg::flip_vert(board);
			bou_pkg::OP_DFLIP: misc_in = bou_pkg::flip_diag(board);
			bou_pkg::OP_ROTCW: misc_in = bou_pkg::flip_vert(bou_pkg::flip_diag(board));
			bou_pkg::OP_ROTCCW: misc_in = bou_pkg::flip_diag(bou_pkg::flip_vert(board));
			bou_pkg::OP_GENSHIFT: misc_in = bou_pkg::signed_shift(board, shift_amount);
			default: misc_in = board;
		endcase
		unique case (grp_in)
			bou_pkg::GRP_SHIFT: data_d1 = bou_pkg::step_one(board, dir_in);
			bou_pkg::GRP_FILL, bou_pkg::GRP_ATTACK: data_d1 = fill1;
			default: data_d1 = misc_in;
		endcase
		for (int i = 0; i < 8; i++) begin
			bytecnt_d1[i] = 4'(board[8*i]) + 4'(board[8*i+1]) + 4'(board[8*i+2])
				+ 4'(board[8*i+3]) + 4'(board[8*i+4]) + 4'(board[8*i+5])
				+ 4'(board[8*i+6]) + 4'(board[8*i+7]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req_valid) begin
			kind_s1 <= kind;
			data_s1 <= data_d1;
			empty_s1 <= efill1;
			bytecnt_s1 <= bytecnt_d1;
		end
	end

	// stage 2: second fill step, count combine
	bou_pkg::grp_t grp_1;
	bou_pkg::dir_t dir_1;
	bou_pkg::op_t op_1;
	logic [63:0] fill2, efill2;
	logic [6:0] pop_sum;
	logic [2:0] lo_byte, hi_byte, lo_bit, hi_bit;
	logic [7:0] lo_val, hi_val;
	logic board_zero;
	logic [bou_pkg::COUNT_W-1:0] cnt_d2;
	logic zero_d2;

	always_comb begin
		grp_1 = bou_pkg::grp_t'(kind_s1[4:3]);
		dir_1 = bou_pkg::dir_t'(kind_s1[2:0]);
		op_1 = bou_pkg::op_t'(kind_s1[2:0]);
		fill2 = data_s1 | (empty_s1 & bou_pkg::dir_move(data_s1, dir_1, 2'd1));
		efill2 = empty_s1 & bou_pkg::dir_move(empty_s1, dir_1, 2'd1);

		pop_sum = '0;
		for (int i = 0; i < 8; i++) begin
			pop_sum = pop_sum + 7'(bytecnt_s1[i]);
		end

		lo_byte = '0;
		hi_byte = '0;
		for (int i = 7; i >= 0; i--) begin
			if (data_s1[8*i +: 8] != 8'd0) begin
				lo_byte = 3'(i);
			end
		end
		for (int i = 0; i < 8; i++) begin
			if (data_s1[8*i +: 8] != 8'd0) begin
				hi_byte = 3'(i);
			end
		end
		lo_val = data_s1[{lo_byte, 3'd0} +: 8];
		hi_val = data_s1[{hi_byte, 3'd0} +: 8];
		lo_bit = '0;
		hi_bit = '0;
		for (int i = 7; i >= 0; i--) begin
			if (lo_val[i]) begin
				lo_bit = 3'(i);
			end
		end
		for (int i = 0; i < 8; i++) begin
			if (hi_val[i]) begin
				hi_bit = 3'(i);
			end
		end
		board_zero = (data_s1 == '0);

		cnt_d2 = '0;
		zero_d2 = 1'b0;
		if (grp_1 == bou_pkg::GRP_MISC) begin
			unique case (op_1)
				bou_pkg::OP_SCAN: begin
					cnt_d2 = {1'b0, lo_byte, lo_bit};
					zero_d2 = board_zero;
				end
				bou_pkg::OP_POPCNT: cnt_d2 = pop_sum;
				bou_pkg::OP_LZC: cnt_d2 = board_zero ? 7'd64 : {1'b0, ~hi_byte, ~hi_bit};
				default: cnt_d2 = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			kind_s2 <= kind_s1;
			data_s2 <= (grp_1 == bou_pkg::GRP_FILL || grp_1 == bou_pkg::GRP_ATTACK)
				? fill2 : data_s1;
			empty_s2 <= efill2;
			cnt_s2 <= cnt_d2;
			zero_s2 <= zero_d2;
		end
	end

	// stage 3: last fill step, attack shift, result select
	bou_pkg::grp_t grp_2;
	bou_pkg::dir_t dir_2;
	bou_pkg::op_t op_2;
	logic [63:0] fill3, rb_d3;

	always_comb begin
		grp_2 = bou_pkg::grp_t'(kind_s2[4:3]);
		dir_2 = bou_pkg::dir_t'(kind_s2[2:0]);
		op_2 = bou_pkg::op_t'(kind_s2[2:0]);
		fill3 = data_s2 | (empty_s2 & bou_pkg::dir_move(data_s2, dir_2, 2'd2));
		unique case (grp_2)
			bou_pkg::GRP_SHIFT: rb_d3 = data_s2;
			bou_pkg::GRP_FILL: rb_d3 = fill3;
			bou_pkg::GRP_ATTACK: rb_d3 = bou_pkg::step_one(fill3, dir_2);
			default: begin
				if (op_2 == bou_pkg::OP_SCAN || op_2 == bou_pkg::OP_POPCNT
						|| op_2 == bou_pkg::OP_LZC) begin
					rb_d3 = '0;
				end else begin
					rb_d3 = data_s2;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv_s3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && vld_s2) begin
			rb_s3 <= rb_d3;
			cnt_s3 <= cnt_s2;
			zero_s3 <= zero_s2;
		end
	end

	assign rsp_valid = vld_s3;
	assign result_board = rb_s3;
	assign result_count = cnt_s3;
	assign zero_input = zero_s3;

	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && zero_input |-> result_count == '0 && result_board == '0)
		else $error("zero flag with non-zero result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> result_count <= 7'd64)
		else $error("count out of range");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv_s2 |=> vld_s1 && $stable(data_s1) && $stable(kind_s1))
		else $error("stage 1 request lost while stalled");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !adv_s3 |=> vld_s2 && $stable(data_s2) && $stable(cnt_s2))
		else $error("stage 2 request lost while stalled");

endmodule
